[hdl/gbs_pkg.sv]
// Shared types and constants of the Gaussian background subtraction block.
`default_nettype none
package gbs_pkg;

  // Field widths of the item channels.
  localparam int OP_W = 2;
  localparam int IDX_W = 17;
  localparam int PIX_W = 8;

  // Register widths.
  localparam int FRAMES_W = 9;
  localparam int ALPHA_W = 9;
  localparam int BETA_W = 8;

  // Datapath widths.
  localparam int SUM_W = 16;
  localparam int SQ_W = 40;
  localparam int MEAN_DIV_W = 24;
  localparam int AD_W = 16;
  localparam int ADSQ_W = 2 * AD_W;
  localparam int ROOT_W = 20;
  localparam int PROD_W = ALPHA_W + ROOT_W + 1;

  // Configuration port.
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_LEARN_MEAN = 2'd0;
  localparam logic [OP_W-1:0] OP_LEARN_SPREAD = 2'd1;
  localparam logic [OP_W-1:0] OP_CLASSIFY = 2'd2;

  // Register indexes (byte address divided by four).
  localparam logic [1:0] REG_TRAINING_FRAMES = 2'd0;
  localparam logic [1:0] REG_ALPHA_GAIN = 2'd1;
  localparam logic [1:0] REG_BETA_OFFSET = 2'd2;

  // Register reset values.
  localparam logic [FRAMES_W-1:0] TRAINING_FRAMES_RST = 9'd150;
  localparam logic [ALPHA_W-1:0] ALPHA_GAIN_RST = 9'd253;
  localparam logic [BETA_W-1:0] BETA_OFFSET_RST = 8'd3;

  typedef struct packed {
    logic [OP_W-1:0] operation;
    logic [IDX_W-1:0] pixel_index;
    logic [PIX_W-1:0] pixel_value;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] result_index;
    logic foreground;
  } out_item_t;

  typedef struct packed {
    logic [FRAMES_W-1:0] frames;
    logic [ALPHA_W-1:0] alpha;
    logic [BETA_W-1:0] beta;
  } cfg_t;

  // One item as the front hands it to the back.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic in_frame;
    logic [IDX_W-1:0] idx;
    logic [PIX_W-1:0] pix;
  } work_t;

  typedef struct packed {
    logic avail;
    work_t item;
  } fq_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } bk_ctl_t;

  // Payload that rides along the mean divider.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic in_frame;
    logic [IDX_W-1:0] idx;
    logic [PIX_W-1:0] pix;
    logic [SQ_W-1:0] sq;
  } sb1_t;

  // Payload that rides along the variance divider and the root unit.
  typedef struct packed {
    logic in_frame;
    logic [IDX_W-1:0] idx;
    logic [AD_W-1:0] ad;
  } sb2_t;

endpackage
`default_nettype wire

[hdl/gbs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module gbs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic clk,
  input  wire logic we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; the data holds while re is low.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[hdl/gbs_div.sv]
// Pipelined restoring divider by the frame count, one quotient bit per stage.
`default_nettype none
module gbs_div #(
  parameter int NUM_W = 24,
  parameter int SB_W = 1
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic en,
  input  wire logic [gbs_pkg::FRAMES_W-1:0] den,
  input  wire logic vld_in,
  input  wire logic [NUM_W-1:0] num_in,
  input  wire logic [SB_W-1:0] sb_in,
  output logic vld_out,
  output logic [NUM_W-1:0] quo_out,
  output logic [SB_W-1:0] sb_out
);

  localparam int DW = gbs_pkg::FRAMES_W;

  logic [NUM_W-1:0] vld_r;
  logic [DW-1:0] rem_r [NUM_W];
  logic [NUM_W-1:0] nq_r [NUM_W];
  logic [SB_W-1:0] sb_r [NUM_W];
  logic [DW-1:0] rem_nxt [NUM_W];
  logic [NUM_W-1:0] nq_nxt [NUM_W];

  // Each stage shifts in one dividend bit and takes the divisor off if it fits.
  // The low end of nq collects quotient bits as the dividend shifts out the top.
  for (genvar g = 0; g < NUM_W; g++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [NUM_W-1:0] nq_in;
    logic [DW:0] trial;
    logic ge;
    if (g == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in = num_in;
    end else begin : g_next
      assign rem_in = rem_r[g-1];
      assign nq_in = nq_r[g-1];
    end
    assign trial = {rem_in, nq_in[NUM_W-1]};
    assign ge = trial >= {1'b0, den};
    assign rem_nxt[g] = ge ? DW'(trial - {1'b0, den}) : trial[DW-1:0];
    assign nq_nxt[g] = {nq_in[NUM_W-2:0], ge};
  end

  // Valid chain.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NUM_W-2:0], vld_in};
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (en) begin
      sb_r[0] <= sb_in;
      for (int i = 0; i < NUM_W; i++) begin
        rem_r[i] <= rem_nxt[i];
        nq_r[i] <= nq_nxt[i];
      end
      for (int i = 1; i < NUM_W; i++) begin
        sb_r[i] <= sb_r[i-1];
      end
    end
  end

  assign vld_out = vld_r[NUM_W-1];
  assign quo_out = nq_r[NUM_W-1];
  assign sb_out = sb_r[NUM_W-1];

endmodule
`default_nettype wire

[hdl/gbs_sqrt.sv]
// Pipelined integer square root, two radicand bits per stage.
`default_nettype none
module gbs_sqrt #(
  parameter int SB_W = 1
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic en,
  input  wire logic vld_in,
  input  wire logic [gbs_pkg::SQ_W-1:0] val_in,
  input  wire logic [SB_W-1:0] sb_in,
  output logic vld_out,
  output logic [gbs_pkg::ROOT_W-1:0] root_out,
  output logic [SB_W-1:0] sb_out
);

  localparam int VW = gbs_pkg::SQ_W;
  localparam int RW = gbs_pkg::ROOT_W;
  localparam int NST = RW;

  logic [NST-1:0] vld_r;
  logic [RW+1:0] rem_r [NST];
  logic [RW-1:0] root_r [NST];
  logic [VW-1:0] val_r [NST];
  logic [SB_W-1:0] sb_r [NST];
  logic [RW+1:0] rem_nxt [NST];
  logic [RW-1:0] root_nxt [NST];
  logic [VW-1:0] val_nxt [NST];

  // Digit recurrence: bring down two bits, try 4*root+1 against the remainder.
  for (genvar g = 0; g < NST; g++) begin : g_stage
    logic [RW+1:0] rem_in;
    logic [RW-1:0] root_in;
    logic [VW-1:0] val_in_s;
    logic [RW+3:0] shifted;
    logic [RW+3:0] trial;
    logic ge;
    if (g == 0) begin : g_first
      assign rem_in = '0;
      assign root_in = '0;
      assign val_in_s = val_in;
    end else begin : g_next
      assign rem_in = rem_r[g-1];
      assign root_in = root_r[g-1];
      assign val_in_s = val_r[g-1];
    end
    assign shifted = {rem_in, val_in_s[VW-1:VW-2]};
    assign trial = {2'b00, root_in, 2'b01};
    assign ge = shifted >= trial;
    assign rem_nxt[g] = ge ? (RW+2)'(shifted - trial) : shifted[RW+1:0];
    assign root_nxt[g] = {root_in[RW-2:0], ge};
    assign val_nxt[g] = {val_in_s[VW-3:0], 2'b00};
  end

  // Valid chain.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], vld_in};
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (en) begin
      sb_r[0] <= sb_in;
      for (int i = 0; i < NST; i++) begin
        rem_r[i] <= rem_nxt[i];
        root_r[i] <= root_nxt[i];
        val_r[i] <= val_nxt[i];
      end
      for (int i = 1; i < NST; i++) begin
        sb_r[i] <= sb_r[i-1];
      end
    end
  end

  assign vld_out = vld_r[NST-1];
  assign root_out = root_r[NST-1];
  assign sb_out = sb_r[NST-1];

endmodule
`default_nettype wire

[hdl/gbs_front.sv]
// Front part: accepts items, sorts out those that do nothing, and queues the rest.
`default_nettype none
module gbs_front #(
  parameter int FRAME_WIDTH = 320,
  parameter int FRAME_HEIGHT = 240
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  output logic full,
  input  wire gbs_pkg::in_item_t in_item,
  input  wire gbs_pkg::bk_ctl_t ctl,
  output gbs_pkg::fq_t fq
);

  localparam int PIXEL_COUNT = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int PW = $clog2(gbs_pkg::QUEUE_DEPTH);
  localparam int CW = PW + 1;

  gbs_pkg::work_t q_r [gbs_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_r, wr_nxt;
  logic [PW-1:0] rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic accept;
  logic keep;
  logic in_frame;
  logic enq;
  logic deq;

  assign full = (cnt_r == CW'(gbs_pkg::QUEUE_DEPTH)) || ctl.clearing;
  assign accept = push && !full;
  assign in_frame = 32'(in_item.pixel_index) < 32'(PIXEL_COUNT);

  // Learning outside the frame and unknown operations leave no trace.
  always_comb begin
    case (in_item.operation) inside
      gbs_pkg::OP_LEARN_MEAN, gbs_pkg::OP_LEARN_SPREAD: keep = in_frame;
      gbs_pkg::OP_CLASSIFY: keep = 1'b1;
      default: keep = 1'b0;
    endcase
  end

  assign enq = accept && keep;
  assign deq = ctl.pop;

  // Queue pointers and fill count.
  always_comb begin
    wr_nxt = enq ? wr_r + 1'b1 : wr_r;
    rd_nxt = deq ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r;
    if (enq && !deq) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!enq && deq) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_r <= wr_nxt;
      rd_r <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (enq) begin
      q_r[wr_r] <= '{op: in_item.operation, in_frame: in_frame,
                     idx: in_item.pixel_index, pix: in_item.pixel_value};
    end
  end

  assign fq.avail = cnt_r != '0;
  assign fq.item = q_r[rd_r];

endmodule
`default_nettype wire

[hdl/gbs_back.sv]
// Back part: per-pixel stores, mean and spread learning, and the classify pipeline.
`default_nettype none
module gbs_back #(
  parameter int FRAME_WIDTH = 320,
  parameter int FRAME_HEIGHT = 240
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire gbs_pkg::cfg_t cfg,
  input  wire gbs_pkg::fq_t fq,
  output gbs_pkg::bk_ctl_t ctl,
  output logic empty,
  input  wire logic pop,
  output gbs_pkg::out_item_t out_item
);

  localparam int PIXEL_COUNT = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int IDX_SPAN = 2 ** gbs_pkg::IDX_W;
  localparam int MEM_DEPTH = (PIXEL_COUNT > IDX_SPAN) ? IDX_SPAN : PIXEL_COUNT;
  localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int HAZ_DEPTH = gbs_pkg::MEAN_DIV_W + 4;
  localparam int SB1_W = $bits(gbs_pkg::sb1_t);
  localparam int SB2_W = $bits(gbs_pkg::sb2_t);

  logic adv;
  logic issue;
  logic hazard;
  logic [gbs_pkg::FRAMES_W-1:0] n_eff;

  // Clearing pass over both stores after reset.
  logic clearing_r;
  logic [AW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      if (clr_addr_r == AW'(MEM_DEPTH - 1)) begin
        clearing_r <= 1'b0;
      end else begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
    end
  end

  // A frame count of zero counts as one.
  assign n_eff = (cfg.frames == '0) ? gbs_pkg::FRAMES_W'(1) : cfg.frames;

  // Result queue of two entries; the whole pipeline advances while it has room.
  gbs_pkg::out_item_t of_r [2];
  logic of_wr_r;
  logic of_rd_r;
  logic [1:0] of_cnt_r;
  logic of_push;
  logic of_pop;
  logic t2_vld_r;
  gbs_pkg::out_item_t t2_item_r;

  assign adv = of_cnt_r != 2'd2;
  assign empty = of_cnt_r == 2'd0;
  assign out_item = of_r[of_rd_r];
  assign of_push = adv && t2_vld_r;
  assign of_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      of_wr_r <= 1'b0;
      of_rd_r <= 1'b0;
      of_cnt_r <= 2'd0;
    end else begin
      if (of_push) begin
        of_wr_r <= !of_wr_r;
      end
      if (of_pop) begin
        of_rd_r <= !of_rd_r;
      end
      if (of_push && !of_pop) begin
        of_cnt_r <= of_cnt_r + 2'd1;
      end else if (!of_push && of_pop) begin
        of_cnt_r <= of_cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (of_push) begin
      of_r[of_wr_r] <= t2_item_r;
    end
  end

  // Same-index guard: a learning item in flight blocks any item on its pixel
  // until its store write is done.
  logic [HAZ_DEPTH-1:0] hz_vld_r;
  logic [gbs_pkg::IDX_W-1:0] hz_idx_r [HAZ_DEPTH];
  logic is_learn;

  always_comb begin
    hazard = 1'b0;
    for (int k = 0; k < HAZ_DEPTH; k++) begin
      if (hz_vld_r[k] && (hz_idx_r[k] == fq.item.idx)) begin
        hazard = 1'b1;
      end
    end
  end

  assign is_learn = (fq.item.op == gbs_pkg::OP_LEARN_MEAN) ||
                    (fq.item.op == gbs_pkg::OP_LEARN_SPREAD);
  assign issue = adv && !clearing_r && fq.avail && !hazard;
  assign ctl.pop = issue;
  assign ctl.clearing = clearing_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hz_vld_r <= '0;
    end else if (adv) begin
      hz_vld_r <= {hz_vld_r[HAZ_DEPTH-2:0], issue && is_learn};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hz_idx_r[0] <= fq.item.idx;
      for (int k = 1; k < HAZ_DEPTH; k++) begin
        hz_idx_r[k] <= hz_idx_r[k-1];
      end
    end
  end

  // Issue stage: both stores are read at the item's index.
  logic p1_vld_r;
  gbs_pkg::work_t p1_r;
  logic [gbs_pkg::SUM_W-1:0] sum_rd;
  logic [gbs_pkg::SQ_W-1:0] sq_rd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else if (adv) begin
      p1_vld_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_r <= fq.item;
    end
  end

  // Learn mean: saturating add into the pixel sum.
  logic [gbs_pkg::SUM_W:0] sum_add;
  logic [gbs_pkg::SUM_W-1:0] sum_sat;
  logic sum_we;
  logic [AW-1:0] sum_waddr;
  logic [gbs_pkg::SUM_W-1:0] sum_wdata;

  assign sum_add = {1'b0, sum_rd} + (gbs_pkg::SUM_W+1)'(p1_r.pix);
  assign sum_sat = sum_add[gbs_pkg::SUM_W] ? '1 : sum_add[gbs_pkg::SUM_W-1:0];
  assign sum_we = clearing_r ||
                  (adv && p1_vld_r && (p1_r.op == gbs_pkg::OP_LEARN_MEAN));
  assign sum_waddr = clearing_r ? clr_addr_r : p1_r.idx[AW-1:0];
  assign sum_wdata = clearing_r ? '0 : sum_sat;

  gbs_ram #(
    .WIDTH(gbs_pkg::SUM_W),
    .DEPTH(MEM_DEPTH)
  ) u_sum_ram (
    .clk(clk),
    .we(sum_we),
    .waddr(sum_waddr),
    .wdata(sum_wdata),
    .re(adv),
    .raddr(fq.item.idx[AW-1:0]),
    .rdata(sum_rd)
  );

  // Mean in Q8.8 with rounding: (sum*256 + n/2) / n.
  logic [gbs_pkg::MEAN_DIV_W-1:0] mean_num;
  gbs_pkg::sb1_t d1_sb_in;
  logic [SB1_W-1:0] d1_sb_out;
  gbs_pkg::sb1_t d1_sb;
  logic d1_vld;
  logic [gbs_pkg::MEAN_DIV_W-1:0] d1_quo;

  assign mean_num = {sum_rd, 8'h00} + gbs_pkg::MEAN_DIV_W'(n_eff >> 1);
  assign d1_sb_in = '{op: p1_r.op, in_frame: p1_r.in_frame, idx: p1_r.idx,
                      pix: p1_r.pix, sq: sq_rd};
  assign d1_sb = gbs_pkg::sb1_t'(d1_sb_out);

  gbs_div #(
    .NUM_W(gbs_pkg::MEAN_DIV_W),
    .SB_W(SB1_W)
  ) u_mean_div (
    .clk(clk),
    .rst_n(rst_n),
    .en(adv),
    .den(n_eff),
    .vld_in(p1_vld_r),
    .num_in(mean_num),
    .sb_in(SB1_W'(d1_sb_in)),
    .vld_out(d1_vld),
    .quo_out(d1_quo),
    .sb_out(d1_sb_out)
  );

  // Absolute deviation of the pixel from the saturated mean.
  logic [gbs_pkg::SUM_W-1:0] mean_sat;
  logic [gbs_pkg::AD_W-1:0] pix_q;
  logic [gbs_pkg::AD_W-1:0] ad_nxt;
  logic m1_vld_r;
  gbs_pkg::sb1_t m1_r;
  logic [gbs_pkg::AD_W-1:0] m1_ad_r;

  assign mean_sat = (d1_quo[gbs_pkg::MEAN_DIV_W-1:gbs_pkg::SUM_W] != '0) ? '1 :
                    d1_quo[gbs_pkg::SUM_W-1:0];
  assign pix_q = {d1_sb.pix, 8'h00};
  assign ad_nxt = (pix_q >= mean_sat) ? (pix_q - mean_sat) : (mean_sat - pix_q);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r <= 1'b0;
    end else if (adv) begin
      m1_vld_r <= d1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_r <= d1_sb;
      m1_ad_r <= ad_nxt;
    end
  end

  // Squared deviation.
  logic m2_vld_r;
  gbs_pkg::sb1_t m2_r;
  logic [gbs_pkg::AD_W-1:0] m2_ad_r;
  logic [gbs_pkg::ADSQ_W-1:0] m2_adsq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_vld_r <= 1'b0;
    end else if (adv) begin
      m2_vld_r <= m1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_r <= m1_r;
      m2_ad_r <= m1_ad_r;
      m2_adsq_r <= gbs_pkg::ADSQ_W'(m1_ad_r) * gbs_pkg::ADSQ_W'(m1_ad_r);
    end
  end

  // Learn spread: saturating add into the square sum.
  logic [gbs_pkg::SQ_W:0] sq_add;
  logic [gbs_pkg::SQ_W-1:0] sq_sat;
  logic sq_we;
  logic [AW-1:0] sq_waddr;
  logic [gbs_pkg::SQ_W-1:0] sq_wdata;

  assign sq_add = {1'b0, m2_r.sq} + (gbs_pkg::SQ_W+1)'(m2_adsq_r);
  assign sq_sat = sq_add[gbs_pkg::SQ_W] ? '1 : sq_add[gbs_pkg::SQ_W-1:0];
  assign sq_we = clearing_r ||
                 (adv && m2_vld_r && (m2_r.op == gbs_pkg::OP_LEARN_SPREAD));
  assign sq_waddr = clearing_r ? clr_addr_r : m2_r.idx[AW-1:0];
  assign sq_wdata = clearing_r ? '0 : sq_sat;

  gbs_ram #(
    .WIDTH(gbs_pkg::SQ_W),
    .DEPTH(MEM_DEPTH)
  ) u_sq_ram (
    .clk(clk),
    .we(sq_we),
    .waddr(sq_waddr),
    .wdata(sq_wdata),
    .re(adv),
    .raddr(fq.item.idx[AW-1:0]),
    .rdata(sq_rd)
  );

  // Variance in Q16.16: square sum divided by the frame count.
  gbs_pkg::sb2_t d2_sb_in;
  logic d2_vld;
  logic [gbs_pkg::SQ_W-1:0] d2_quo;
  logic [SB2_W-1:0] d2_sb_out;

  assign d2_sb_in = '{in_frame: m2_r.in_frame, idx: m2_r.idx, ad: m2_ad_r};

  gbs_div #(
    .NUM_W(gbs_pkg::SQ_W),
    .SB_W(SB2_W)
  ) u_var_div (
    .clk(clk),
    .rst_n(rst_n),
    .en(adv),
    .den(n_eff),
    .vld_in(m2_vld_r && (m2_r.op == gbs_pkg::OP_CLASSIFY)),
    .num_in(m2_r.sq),
    .sb_in(SB2_W'(d2_sb_in)),
    .vld_out(d2_vld),
    .quo_out(d2_quo),
    .sb_out(d2_sb_out)
  );

  // Standard deviation in Q8.8.
  logic s_vld;
  logic [gbs_pkg::ROOT_W-1:0] s_root;
  logic [SB2_W-1:0] s_sb_out;
  gbs_pkg::sb2_t s_sb;

  gbs_sqrt #(
    .SB_W(SB2_W)
  ) u_sqrt (
    .clk(clk),
    .rst_n(rst_n),
    .en(adv),
    .vld_in(d2_vld),
    .val_in(d2_quo),
    .sb_in(d2_sb_out),
    .vld_out(s_vld),
    .root_out(s_root),
    .sb_out(s_sb_out)
  );

  assign s_sb = gbs_pkg::sb2_t'(s_sb_out);

  // Threshold alpha * (sd + beta).
  logic [gbs_pkg::ROOT_W:0] sd_ofs;
  logic t1_vld_r;
  gbs_pkg::sb2_t t1_sb_r;
  logic [gbs_pkg::PROD_W-1:0] t1_thr_r;

  assign sd_ofs = {1'b0, s_root} + (gbs_pkg::ROOT_W+1)'({cfg.beta, 8'h00});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_vld_r <= 1'b0;
    end else if (adv) begin
      t1_vld_r <= s_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t1_sb_r <= s_sb;
      t1_thr_r <= gbs_pkg::PROD_W'(cfg.alpha) * gbs_pkg::PROD_W'(sd_ofs);
    end
  end

  // Final compare; a pixel outside the frame is never foreground.
  logic fg;

  assign fg = t1_sb_r.in_frame &&
              (gbs_pkg::PROD_W'({t1_sb_r.ad, 8'h00}) > t1_thr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t2_vld_r <= 1'b0;
    end else if (adv) begin
      t2_vld_r <= t1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t2_item_r <= '{result_index: t1_sb_r.idx, foreground: fg};
    end
  end

endmodule
`default_nettype wire

[hdl/gaussian_background_subtraction.sv]
// Top level of the single-Gaussian background subtraction block.
`default_nettype none
// Per-pixel background model over grey 8-bit frames. An item is taken every
// cycle while full is low, and results leave one per cycle while pop is high,
// in input order, each having passed the input queue, the 24-stage mean
// divider, the 40-stage variance divider, the 20-stage square root unit and
// the issue, deviation, square, threshold and compare stages. An item is held
// in the input queue for as long as a learning item for the same pixel index
// is still between its store read and its store write; apart from a result
// side that is full and not being drained, this is the only case that slows
// the flow. After reset the block clears all FRAME_WIDTH*FRAME_HEIGHT entries
// of both per-pixel stores (at most 131072), one entry a cycle, and shows full
// meanwhile; register writes are taken at any time.
module gaussian_background_subtraction #(
  parameter int FRAME_WIDTH = 320,
  parameter int FRAME_HEIGHT = 240
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  output logic full,
  input  wire gbs_pkg::in_item_t in_item,
  output logic empty,
  input  wire logic pop,
  output gbs_pkg::out_item_t out_item,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [gbs_pkg::APB_AW-1:0] paddr,
  input  wire logic [gbs_pkg::APB_DW-1:0] pwdata,
  output logic [gbs_pkg::APB_DW-1:0] prdata,
  output logic pready
);

  logic [gbs_pkg::FRAMES_W-1:0] frames_r;
  logic [gbs_pkg::ALPHA_W-1:0] alpha_r;
  logic [gbs_pkg::BETA_W-1:0] beta_r;
  logic cfg_wr;
  logic [1:0] reg_sel;
  gbs_pkg::cfg_t cfg;
  gbs_pkg::fq_t fq;
  gbs_pkg::bk_ctl_t ctl;

  assign pready = 1'b1;
  assign reg_sel = paddr[gbs_pkg::APB_AW-1:2];
  assign cfg_wr = psel && penable && pwrite && pready;

  // Register writes on the access cycle of a transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_r <= gbs_pkg::TRAINING_FRAMES_RST;
      alpha_r <= gbs_pkg::ALPHA_GAIN_RST;
      beta_r <= gbs_pkg::BETA_OFFSET_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        gbs_pkg::REG_TRAINING_FRAMES: frames_r <= pwdata[gbs_pkg::FRAMES_W-1:0];
        gbs_pkg::REG_ALPHA_GAIN: alpha_r <= pwdata[gbs_pkg::ALPHA_W-1:0];
        gbs_pkg::REG_BETA_OFFSET: beta_r <= pwdata[gbs_pkg::BETA_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_sel)
      gbs_pkg::REG_TRAINING_FRAMES: prdata = gbs_pkg::APB_DW'(frames_r);
      gbs_pkg::REG_ALPHA_GAIN: prdata = gbs_pkg::APB_DW'(alpha_r);
      gbs_pkg::REG_BETA_OFFSET: prdata = gbs_pkg::APB_DW'(beta_r);
      default: prdata = '0;
    endcase
  end

  assign cfg = '{frames: frames_r, alpha: alpha_r, beta: beta_r};

  gbs_front #(
    .FRAME_WIDTH(FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT)
  ) u_front (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .full(full),
    .in_item(in_item),
    .ctl(ctl),
    .fq(fq)
  );

  gbs_back #(
    .FRAME_WIDTH(FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT)
  ) u_back (
    .clk(clk),
    .rst_n(rst_n),
    .cfg(cfg),
    .fq(fq),
    .ctl(ctl),
    .empty(empty),
    .pop(pop),
    .out_item(out_item)
  );

endmodule
`default_nettype wire

[hdl/gbs_checker.sv]
// Port-level checks of the background subtraction block and their binding.
`default_nettype none
module gbs_checker #(
  parameter int FRAME_WIDTH = 320,
  parameter int FRAME_HEIGHT = 240
) (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic full,
  input wire logic empty,
  input wire logic pop,
  input wire gbs_pkg::out_item_t out_item,
  input wire logic pready
);

  localparam int PIXEL_COUNT = FRAME_WIDTH * FRAME_HEIGHT;

  // Reset leaves no result waiting.
  a_empty_after_reset: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  // Reset starts the store clearing, so no item is taken right after it.
  a_full_after_reset: assert property (@(posedge clk) !rst_n |=> full)
    else $error("input taken right after reset");

  // A waiting result stays put until it is taken.
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_item)))
    else $error("waiting result changed before transfer");

  // A pixel outside the frame is never marked foreground.
  a_outside_background: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (32'(out_item.result_index) >= 32'(PIXEL_COUNT)))
      |-> !out_item.foreground)
    else $error("pixel outside the frame marked foreground");

  // The configuration port never inserts wait states.
  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind gaussian_background_subtraction gbs_checker #(
  .FRAME_WIDTH(FRAME_WIDTH),
  .FRAME_HEIGHT(FRAME_HEIGHT)
) u_gbs_checker (
  .clk(clk),
  .rst_n(rst_n),
  .full(full),
  .empty(empty),
  .pop(pop),
  .out_item(out_item),
  .pready(pready)
);
`default_nettype wire
